>>> sv/shtlp_pkg.sv
// Shared types, status codes and state encoding for the string hash table.
package shtlp_pkg;

	localparam logic       OP_INSERT    = 1'b0;
	localparam logic       OP_SEARCH    = 1'b1;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FOUND     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	localparam int         HASH_W       = 32;
	localparam logic [HASH_W-1:0] HASH_MULT = 32'd31;

	typedef struct packed {
		logic       opcode;
		logic [7:0] key_byte;
		logic       key_last;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [9:0] slot;
		logic [9:0] home_slot;
	} result_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_DISPATCH,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_CMP_RD,
		S_CMP_CHK,
		S_COPY_RD,
		S_COPY_WR
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       clr_step;
		logic       mod_step;
		logic       probe_start;
		logic       probe_next;
		logic       meta_write;
		logic       idx_start;
		logic       idx_next;
		logic       copy_write;
		logic       emit;
		logic [2:0] status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_last;
		logic overlong;
		logic op;
		logic valid;
		logic len_eq;
		logic all_probed;
		logic byte_eq;
		logic idx_last;
	} dp_stat_t;

endpackage

>>> sv/shtlp_ctrl.sv
// Control state machine: sequences clear, hash reduction, probing, compare and copy.
module shtlp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 key_last,
	input  shtlp_pkg::dp_stat_t  stat,
	output shtlp_pkg::ctrl_cmd_t cmd,
	output logic                 busy
);
	import shtlp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start && key_last) state_d = S_MOD;
			end
			S_MOD: begin
				if (stat.mod_last) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				state_d = stat.overlong ? S_IDLE : S_PROBE_RD;
			end
			S_PROBE_RD: begin
				state_d = stat.all_probed ? S_IDLE : S_PROBE_CHK;
			end
			S_PROBE_CHK: begin
				if (stat.op == OP_INSERT) begin
					state_d = stat.valid ? S_PROBE_RD : S_COPY_RD;
				end else if (!stat.valid) begin
					state_d = S_IDLE;
				end else begin
					state_d = stat.len_eq ? S_CMP_RD : S_PROBE_RD;
				end
			end
			S_CMP_RD: begin
				state_d = S_CMP_CHK;
			end
			S_CMP_CHK: begin
				if (!stat.byte_eq) state_d = S_PROBE_RD;
				else if (stat.idx_last) state_d = S_IDLE;
				else state_d = S_CMP_RD;
			end
			S_COPY_RD: begin
				state_d = S_COPY_WR;
			end
			S_COPY_WR: begin
				state_d = stat.idx_last ? S_IDLE : S_COPY_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				cmd.accept = start;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
			end
			S_DISPATCH: begin
				if (stat.overlong) begin
					cmd.emit   = 1'b1;
					cmd.status = ST_TOO_LONG;
				end else begin
					cmd.probe_start = 1'b1;
				end
			end
			S_PROBE_RD: begin
				if (stat.all_probed) begin
					cmd.emit   = 1'b1;
					cmd.status = (stat.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
				end
			end
			S_PROBE_CHK: begin
				if (stat.op == OP_INSERT) begin
					if (stat.valid) begin
						cmd.probe_next = 1'b1;
					end else begin
						cmd.meta_write = 1'b1;
						cmd.idx_start  = 1'b1;
					end
				end else if (!stat.valid) begin
					cmd.emit   = 1'b1;
					cmd.status = ST_NOT_FOUND;
				end else if (stat.len_eq) begin
					cmd.idx_start = 1'b1;
				end else begin
					cmd.probe_next = 1'b1;
				end
			end
			S_CMP_CHK: begin
				if (!stat.byte_eq) begin
					cmd.probe_next = 1'b1;
				end else if (stat.idx_last) begin
					cmd.emit   = 1'b1;
					cmd.status = ST_FOUND;
				end else begin
					cmd.idx_next = 1'b1;
				end
			end
			S_COPY_WR: begin
				cmd.copy_write = 1'b1;
				if (stat.idx_last) begin
					cmd.emit   = 1'b1;
					cmd.status = ST_INSERTED;
				end else begin
					cmd.idx_next = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> sv/shtlp_dp.sv
// Datapath: key buffer, hash, modulo unit, probe pointer and the table memories.
module shtlp_dp #(
	parameter int TABLE_SIZE  = 1024,
	parameter int MAX_KEY_LEN = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shtlp_pkg::item_t     item,
	input  shtlp_pkg::ctrl_cmd_t cmd,
	output shtlp_pkg::dp_stat_t  stat,
	output logic                 done,
	output shtlp_pkg::result_t   result
);
	import shtlp_pkg::*;

	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int LEN_W      = $clog2(MAX_KEY_LEN + 1);
	localparam int KI_W       = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
	localparam int BYTE_DEPTH = TABLE_SIZE * (2 ** KI_W);
	localparam int META_W     = LEN_W + 1;
	// modulo unit: partial remainder with one hash byte appended, reciprocal width
	localparam int XW         = SLOT_W + 8;
	localparam int RK         = 2 * SLOT_W + 8;

	localparam logic [SLOT_W:0]   TS_C    = (SLOT_W + 1)'(TABLE_SIZE);
	localparam logic [SLOT_W-1:0] LAST_C  = SLOT_W'(TABLE_SIZE - 1);
	localparam logic [LEN_W-1:0]  MAX_C   = LEN_W'(MAX_KEY_LEN);
	localparam logic [XW-1:0]     TS_X    = XW'(TABLE_SIZE);
	localparam logic [RK-1:0]     RECIP_C =
		RK'(((64'd1 << RK) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

	// key side
	logic [HASH_W-1:0] hash_q, hash_d;
	logic [LEN_W-1:0]  klen_q;
	logic              overlong_q;
	logic              op_q;
	logic [7:0]        kb_mem [0:MAX_KEY_LEN-1];
	logic [7:0]        kb_rd_q;

	// modulo unit
	logic [HASH_W-1:0]  sh_q;
	logic [SLOT_W-1:0]  rem_q;
	logic [2:0]         bit_q;
	logic [XW-1:0]      x_w, x_q;
	logic [XW+RK-1:0]   prod_w;
	logic [7:0]         q_q;
	logic [XW-1:0]      qt_w;

	// probing
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] p_q;
	logic [SLOT_W:0]   n_q;
	logic [KI_W-1:0]   i_q;
	logic [META_W-1:0] meta_mem [0:TABLE_SIZE-1];
	logic [META_W-1:0] meta_rd_q;
	logic [7:0]        byte_mem [0:BYTE_DEPTH-1];
	logic [7:0]        by_rd_q;

	logic              done_q;
	result_t           res_q;
	logic [SLOT_W+9:0] slot_wide, home_wide;

	assign hash_d = HASH_W'(item.key_byte) + hash_q * HASH_MULT;
	assign x_w    = {rem_q, sh_q[HASH_W-1 -: 8]};
	assign prod_w = (XW + RK)'(x_w) * (XW + RK)'(RECIP_C);
	assign qt_w   = XW'(q_q) * TS_X;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q     <= '0;
			klen_q     <= '0;
			overlong_q <= 1'b0;
			op_q       <= OP_INSERT;
			bit_q      <= '0;
			clr_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.accept) begin
				op_q <= item.opcode;
				if (klen_q < MAX_C) klen_q <= klen_q + 1'b1;
				else overlong_q <= 1'b1;
				hash_q <= item.key_last ? '0 : hash_d;
				bit_q  <= '0;
			end else if (cmd.mod_step) begin
				bit_q <= bit_q + 1'b1;
			end
			if (cmd.emit) begin
				klen_q     <= '0;
				overlong_q <= 1'b0;
			end
		end
	end

	// hash modulo table size, one hash byte at a time, top byte first:
	// even step takes the quotient by reciprocal, odd step the remainder
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sh_q  <= hash_d;
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			if (!bit_q[0]) begin
				x_q  <= x_w;
				q_q  <= prod_w[RK+7:RK];
				sh_q <= {sh_q[HASH_W-9:0], 8'd0};
			end else begin
				rem_q <= SLOT_W'(x_q - qt_w);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (klen_q < MAX_C)) kb_mem[klen_q[KI_W-1:0]] <= item.key_byte;
		kb_rd_q <= kb_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_start) begin
			p_q <= rem_q;
			n_q <= '0;
		end else if (cmd.probe_next) begin
			p_q <= (p_q == LAST_C) ? '0 : p_q + 1'b1;
			n_q <= n_q + 1'b1;
		end
		if (cmd.idx_start) i_q <= '0;
		else if (cmd.idx_next) i_q <= i_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) meta_mem[clr_q] <= '0;
		else if (cmd.meta_write) meta_mem[p_q] <= {1'b1, klen_q};
		meta_rd_q <= meta_mem[p_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.copy_write) byte_mem[{p_q, i_q}] <= kb_rd_q;
		by_rd_q <= byte_mem[{p_q, i_q}];
	end

	assign slot_wide = {10'd0, p_q};
	assign home_wide = {10'd0, rem_q};

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.status    <= cmd.status;
			res_q.slot      <= (cmd.status == ST_INSERTED || cmd.status == ST_FOUND) ?
				slot_wide[9:0] : 10'd0;
			res_q.home_slot <= home_wide[9:0];
		end
	end

	always_comb begin
		stat.clr_last   = (clr_q == LAST_C);
		stat.mod_last   = (bit_q == 3'd7);
		stat.overlong   = overlong_q;
		stat.op         = op_q;
		stat.valid      = meta_rd_q[META_W-1];
		stat.len_eq     = (meta_rd_q[LEN_W-1:0] == klen_q);
		stat.all_probed = (n_q == TS_C);
		stat.byte_eq    = (kb_rd_q == by_rd_q);
		stat.idx_last   = (LEN_W'(i_q) == klen_q - 1'b1);
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> sv/string_hash_table_linear_probe.sv
// Top level of the open-addressed string table with linear probing.
//
//  channel | ports                   | handshake
//  --------+-------------------------+-------------------------------------
//  input   | start, busy, item       | taken at an edge with start & !busy
//  result  | done, result            | one-cycle strobe, no back-pressure
//
// A key byte that is not the last one leaves the block idle and busy low.  The
// last byte goes through hash reduction (one hash byte at a time), a dispatch
// step, then a read and check of each probed slot and a read and compare or
// copy of each key byte.  The result is registered and shows in the cycle after the last step.
// After reset a clearing pass over all TABLE_SIZE slots empties the valid map with
// busy held high.  The result side cannot stall; the next item may be taken
// in the cycle its predecessor's result is shown.
module string_hash_table_linear_probe #(
	parameter int TABLE_SIZE  = 1024,
	parameter int MAX_KEY_LEN = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  shtlp_pkg::item_t   item,
	output logic               done,
	output shtlp_pkg::result_t result
);
	import shtlp_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// controller: owns all sequencing, datapath only reacts to commands
	shtlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.key_last (item.key_last),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// datapath: hash, key buffer, slot memories and result register
	shtlp_dp #(
		.TABLE_SIZE  (TABLE_SIZE),
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule

>>> sv/shtlp_checker.sv
// Port-level checker for the string table, bound to the top level.
module shtlp_props (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input shtlp_pkg::item_t   item,
	input logic               done,
	input shtlp_pkg::result_t result
);
	import shtlp_pkg::*;

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.key_last) |=> busy)
		else $error("block idle after last byte of an item");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in a row");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_NOT_FOUND || result.status == ST_FULL ||
			result.status == ST_TOO_LONG)) |-> (result.slot == 10'd0))
		else $error("slot nonzero on a miss");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= ST_TOO_LONG))
		else $error("undefined status code");

endmodule

bind string_hash_table_linear_probe shtlp_props u_shtlp_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

>>> sim/shtlp_checker.sv
// Checker for the string hash table: predicts each key's result and compares it with the block.
module shtlp_checker #(
	parameter int TABLE_SIZE  = 1024,
	parameter int MAX_KEY_LEN = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  shtlp_pkg::item_t   item,
	input  logic               done,
	input  shtlp_pkg::result_t result,
	output int                 errors,
	output int                 pending,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import shtlp_pkg::*;

	// predicted state of the table and of the key being received
	logic [7:0]  cur_key [MAX_KEY_LEN];
	int unsigned cur_len;
	logic [31:0] cur_hash;
	bit          cur_overlong;
	bit          tbl_valid [TABLE_SIZE];
	int unsigned tbl_len [TABLE_SIZE];
	logic [7:0]  tbl_bytes [TABLE_SIZE][MAX_KEY_LEN];
	result_t     expected_q [$];

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		if (errors <= 20) begin
			$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		end
	endtask

	function automatic bit key_matches(int unsigned s);
		if (!tbl_valid[s] || tbl_len[s] != cur_len) begin
			return 0;
		end
		for (int i = 0; i < cur_len; i++) begin
			if (tbl_bytes[s][i] != cur_key[i]) begin
				return 0;
			end
		end
		return 1;
	endfunction

	// one key byte; at the last byte, works out the insert or search result
	task automatic apply_key_byte(item_t it);
		result_t     r;
		int unsigned p;
		bit          finished;
		cur_hash = 32'(it.key_byte) + HASH_MULT * cur_hash;
		if (cur_len < MAX_KEY_LEN) begin
			cur_key[cur_len] = it.key_byte;
			cur_len++;
		end else begin
			cur_overlong = 1;
		end
		if (!it.key_last) begin
			return;
		end
		r.home_slot = 10'(cur_hash % TABLE_SIZE);
		r.slot = '0;
		p = cur_hash % TABLE_SIZE;
		finished = 0;
		if (cur_overlong) begin
			r.status = ST_TOO_LONG;
		end else if (it.opcode == OP_INSERT) begin
			r.status = ST_FULL;
			for (int n = 0; n < TABLE_SIZE && !finished; n++) begin
				if (!tbl_valid[p]) begin
					tbl_valid[p] = 1;
					tbl_len[p] = cur_len;
					for (int i = 0; i < cur_len; i++) tbl_bytes[p][i] = cur_key[i];
					r.status = ST_INSERTED;
					r.slot = 10'(p);
					finished = 1;
				end else begin
					p = (p + 1) % TABLE_SIZE;
				end
			end
		end else begin
			r.status = ST_NOT_FOUND;
			for (int n = 0; n < TABLE_SIZE && !finished; n++) begin
				if (!tbl_valid[p]) begin
					finished = 1;
				end else if (key_matches(p)) begin
					r.status = ST_FOUND;
					r.slot = 10'(p);
					finished = 1;
				end else begin
					p = (p + 1) % TABLE_SIZE;
				end
			end
		end
		expected_q.push_back(r);
		cur_len = 0;
		cur_hash = '0;
		cur_overlong = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int s = 0; s < TABLE_SIZE; s++) tbl_valid[s] = 0;
			cur_len = 0;
			cur_hash = '0;
			cur_overlong = 0;
			expected_q.delete();
			errors = 0;
			checked = 0;
			pending = 0;
		end else begin
			// result first: an item taken at this edge cannot have its result here
			if (done) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result, status", result.status, 0);
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (result.status != want.status)
						report_mismatch("status", result.status, want.status);
					if (result.slot != want.slot)
						report_mismatch("slot", result.slot, want.slot);
					if (result.home_slot != want.home_slot)
						report_mismatch("home_slot", result.home_slot, want.home_slot);
				end
			end
			if (start && !busy) begin
				apply_key_byte(item);
			end
			pending = expected_q.size();
		end
	end

endmodule

>>> sim/tb_string_hash_table_linear_probe.sv
// Testbench top for the string hash table: drives keys and gives the verdict.
module tb_string_hash_table_linear_probe;
	timeunit 1ns;
	timeprecision 1ps;
	import shtlp_pkg::*;

	localparam int TABLE_SIZE  = 1024;
	localparam int MAX_KEY_LEN = 256;
	localparam int POOL_N      = 40;
	localparam int CYCLE_LIMIT = 6_000_000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;
	int      errors;
	int      pending;
	int      checked;

	// key being built for sending; room for overlong keys
	logic [7:0] key_buf [MAX_KEY_LEN + 16];
	int         key_len;
	// keys already inserted, reused for searches that should hit
	logic [7:0] pool_bytes [POOL_N][MAX_KEY_LEN];
	int         pool_len [POOL_N];
	int         bytes_sent;
	int         keys_sent;
	bit         idle_on;
	int         cycles;

	string_hash_table_linear_probe #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_KEY_LEN(MAX_KEY_LEN)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	shtlp_checker #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_KEY_LEN(MAX_KEY_LEN)
	) chk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result),
		.errors (errors),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// hard stop; covers the clearing pass after reset too
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// one byte: optional idle burst, then hold start until the block takes it.
	// busy is registered, so its value at the falling edge holds at the next rise.
	task automatic send_byte(logic op, logic [7:0] b, logic last);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{opcode: op, key_byte: b, key_last: last};
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		bytes_sent++;
	endtask

	// sends key_buf; opcode on non-final bytes is noise, only the last one counts
	task automatic send_key(logic op);
		for (int i = 0; i < key_len; i++) begin
			send_byte(i == key_len - 1 ? op : logic'($urandom_range(0, 1)), key_buf[i],
				i == key_len - 1);
		end
		keys_sent++;
		if (op == OP_INSERT && key_len <= MAX_KEY_LEN) begin
			int k;
			k = $urandom_range(0, POOL_N - 1);
			pool_len[k] = key_len;
			for (int i = 0; i < key_len; i++) pool_bytes[k][i] = key_buf[i];
		end
	endtask

	task automatic random_key(int len);
		key_len = len;
		for (int i = 0; i < len; i++) key_buf[i] = 8'($urandom_range(0, 255));
	endtask

	task automatic fill_key(int len, logic [7:0] v);
		key_len = len;
		for (int i = 0; i < len; i++) key_buf[i] = v;
	endtask

	// pick a stored key if one is there, else a fresh random one
	task automatic pool_key();
		int k;
		k = $urandom_range(0, POOL_N - 1);
		if (pool_len[k] == 0) begin
			random_key($urandom_range(1, 4));
		end else begin
			key_len = pool_len[k];
			for (int i = 0; i < key_len; i++) key_buf[i] = pool_bytes[k][i];
		end
	endtask

	initial begin
		int sel;
		int len;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		idle_on = 0;
		bytes_sent = 0;
		keys_sent = 0;
		for (int k = 0; k < POOL_N; k++) pool_len[k] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, both operations, miss on empty table
		fill_key(1, 8'h00); send_key(OP_SEARCH);
		fill_key(1, 8'h00); send_key(OP_INSERT);
		fill_key(1, 8'hff); send_key(OP_INSERT);
		fill_key(1, 8'h00); send_key(OP_SEARCH);
		fill_key(1, 8'hff); send_key(OP_SEARCH);
		// zero bytes as data: same hash as one zero byte, differs in length
		fill_key(3, 8'h00); send_key(OP_SEARCH);
		fill_key(3, 8'h00); send_key(OP_INSERT);
		fill_key(3, 8'h00); send_key(OP_SEARCH);
		// duplicate insert lands in the next free slot
		fill_key(1, 8'hff); send_key(OP_INSERT);
		// a longer key stored and found again, then one byte too many
		random_key(40); send_key(OP_INSERT);
		send_key(OP_SEARCH);
		fill_key(MAX_KEY_LEN + 1, 8'ha5); send_key(OP_INSERT);
		random_key(2); send_key(OP_SEARCH);

		// random: mostly short keys, hits drawn from the pool, a few longer ones
		while (bytes_sent < 440) begin
			idle_on = $urandom_range(0, 1);
			sel = $urandom_range(0, 99);
			if (sel < 8)
				len = $urandom_range(7, 24);
			else
				len = $urandom_range(1, 6);
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				random_key(len);
				send_key(OP_INSERT);
			end else if (sel < 85) begin
				pool_key();
				send_key(OP_SEARCH);
			end else begin
				random_key(len);
				send_key(OP_SEARCH);
			end
		end

		// last part, no idling: a few inserts and searches back to back
		idle_on = 0;
		for (int i = 0; i < 4; i++) begin
			random_key($urandom_range(1, 6));
			send_key(OP_INSERT);
		end
		for (int i = 0; i < 6; i++) begin
			pool_key();
			send_key(OP_SEARCH);
		end
		fill_key(5, 8'h7e); send_key(OP_SEARCH);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("ran %0d keys in %0d bytes, %0d results checked", keys_sent, bytes_sent,
			checked);
		$display("covered inserts, hits, misses, duplicates, zero bytes, an overlong key");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
